/* design/mbrd_pkg.sv */
// Shared types and constants of the memory bus region decoder.
// Holds the request and response payload structs, request, size and status codes
// and the fixed address map. No dependencies.
package mbrd_pkg;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] address;
        logic [1:0]  access_size;
        logic [31:0] write_data;
    } mbrd_req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [2:0]  status;
    } mbrd_rsp_t;

    // Request types.
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_FETCH = 2'd2;
    localparam logic [1:0] REQ_LOAD  = 2'd3;

    // Access sizes.
    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;

    // Status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_IO        = 3'd1;
    localparam logic [2:0] ST_ROM_WRITE = 3'd2;
    localparam logic [2:0] ST_UNMAPPED  = 3'd3;
    localparam logic [2:0] ST_BEYOND    = 3'd4;

    // Address map.
    localparam logic [31:0] EXT_BASE   = 32'h0200_0000;
    localparam logic [31:0] INT_BASE   = 32'h0300_0000;
    localparam logic [31:0] IO_BASE    = 32'h0400_0000;
    localparam logic [31:0] IO_LAST    = 32'h0400_03FE;
    localparam logic [31:0] ROM_BASE   = 32'h0800_0000;
    localparam logic [31:0] ROM_LAST   = 32'h0DFF_FFFF;
    localparam logic [31:0] FETCH_MISS = 32'hFFFF_FFFF;

endpackage

/* design/mbrd_channels.sv */
// Valid/ready channel interfaces for bus requests and responses.
// Depends on mbrd_pkg for the payload structs.
interface mbrd_req_if import mbrd_pkg::*; ();
    logic      valid;
    logic      ready;
    mbrd_req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface mbrd_rsp_if import mbrd_pkg::*; ();
    logic      valid;
    logic      ready;
    mbrd_rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* design/mbrd_byte_ram.sv */
// Single-port byte-wide synchronous RAM with a registered read.
// No dependencies.
module mbrd_byte_ram #(
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [7:0]               wdata,
    output logic [7:0]               rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

/* design/memory_bus_region_decoder.sv */
// Memory bus region decoder: one request transfer in, one response transfer out.
// A request is taken only in the idle state; its bytes then move in the run state, a read
// also passes the tail state, and the response is loaded from the done state, which a
// request that moves no byte enters directly. Bytes move one per cycle through the single
// port of the selected byte RAM; the next request is taken once the response is loaded,
// and a held response stalls the following request only once that one is ready to answer.
// Reset clears the control state only; the RAM contents stay undefined until written.
module memory_bus_region_decoder
    import mbrd_pkg::*;
#(
    parameter int EXT_RAM_BYTES = 262144,
    parameter int INT_RAM_BYTES = 32768,
    parameter int ROM_BYTES     = 1048576
) (
    input  logic       clk,
    input  logic       rst_n,
    mbrd_req_if.sink   request,
    mbrd_rsp_if.source response
);

    localparam int EXT_AW = $clog2(EXT_RAM_BYTES);
    localparam int INT_AW = $clog2(INT_RAM_BYTES);
    localparam int ROM_AW = $clog2(ROM_BYTES);
    localparam int MAX_A  = (EXT_AW > INT_AW) ? EXT_AW : INT_AW;
    // The byte pointer is wide enough for the largest of the three stores.
    localparam int PTR_W  = (MAX_A > ROM_AW) ? MAX_A : ROM_AW;

    localparam logic [PTR_W-1:0] EXT_LAST = PTR_W'(EXT_RAM_BYTES - 1);
    localparam logic [PTR_W-1:0] INT_LAST = PTR_W'(INT_RAM_BYTES - 1);
    localparam logic [PTR_W-1:0] ROM_LAST_OFF = PTR_W'(ROM_BYTES - 1);

    typedef enum logic [1:0] {RG_EXT, RG_INT, RG_ROM, RG_NONE} region_t;
    typedef enum logic [1:0] {S_IDLE, S_RUN, S_TAIL, S_DONE} state_t;

    state_t      state_reg;
    region_t     region_reg;
    logic        wr_reg;
    logic [PTR_W-1:0] ptr_reg;
    logic [2:0]  cnt_reg;
    logic [1:0]  idx_reg;
    logic [31:0] wdata_reg;
    logic [31:0] rdata_reg;
    logic [2:0]  status_reg;
    logic        rd_pend_reg;
    logic [1:0]  rd_lane_reg;
    logic        out_valid_reg;
    logic [31:0] out_rdata_reg;
    logic [2:0]  out_status_reg;

    // Decode of the request currently offered on the channel.
    region_t     d_region;
    logic        d_wr;
    logic [PTR_W-1:0] d_ptr;
    logic [2:0]  d_cnt;
    logic [31:0] d_rdata;
    logic [2:0]  d_status;
    logic [2:0]  size_n;
    logic [31:0] ext_off;
    logic [31:0] int_off;
    logic [31:0] rom_off;
    logic        in_rom_win;

    logic [1:0]  req_code;
    logic [31:0] req_addr;

    assign req_code = request.payload.req_type;
    assign req_addr = request.payload.address;
    assign ext_off  = req_addr - EXT_BASE;
    assign int_off  = req_addr - INT_BASE;
    assign rom_off  = req_addr - ROM_BASE;
    assign in_rom_win = (req_addr >= ROM_BASE) && (req_addr <= ROM_LAST);

    always_comb
    begin
        case (request.payload.access_size)
            SZ_BYTE: size_n = 3'd1;
            SZ_HALF: size_n = 3'd2;
            SZ_WORD: size_n = 3'd4;
            default: size_n = 3'd0;
        endcase
    end

    always_comb
    begin
        d_region = RG_NONE;
        d_wr     = 1'b0;
        d_ptr    = '0;
        d_cnt    = 3'd0;
        d_rdata  = 32'd0;
        d_status = ST_OK;
        case (req_code)
            REQ_LOAD:
            begin
                // An image load stores the low byte at the raw offset.
                if (req_addr < 32'(ROM_BYTES))
                begin
                    d_region = RG_ROM;
                    d_wr     = 1'b1;
                    d_cnt    = 3'd1;
                    d_ptr    = req_addr[PTR_W-1:0];
                end
                else
                begin
                    d_status = ST_BEYOND;
                end
            end
            REQ_FETCH:
            begin
                if (in_rom_win)
                begin
                    if (rom_off < 32'(ROM_BYTES))
                    begin
                        d_region = RG_ROM;
                        d_cnt    = 3'd4;
                        d_ptr    = rom_off[PTR_W-1:0];
                    end
                    else
                    begin
                        d_status = ST_BEYOND;
                    end
                end
                else
                begin
                    d_rdata = FETCH_MISS;
                end
            end
            default:
            begin
                d_wr = (req_code == REQ_WRITE);
                if ((req_addr >= EXT_BASE) && (ext_off < 32'(EXT_RAM_BYTES)))
                begin
                    d_region = RG_EXT;
                    d_cnt    = size_n;
                    d_ptr    = ext_off[PTR_W-1:0];
                end
                else if ((req_addr >= INT_BASE) && (int_off < 32'(INT_RAM_BYTES)))
                begin
                    d_region = RG_INT;
                    d_cnt    = size_n;
                    d_ptr    = int_off[PTR_W-1:0];
                end
                else if ((req_addr >= IO_BASE) && (req_addr <= IO_LAST))
                begin
                    d_status = ST_IO;
                end
                else if (in_rom_win)
                begin
                    if (d_wr)
                    begin
                        d_status = ST_ROM_WRITE;
                    end
                    else if (rom_off < 32'(ROM_BYTES))
                    begin
                        d_region = RG_ROM;
                        d_cnt    = size_n;
                        d_ptr    = rom_off[PTR_W-1:0];
                    end
                    else
                    begin
                        d_status = ST_BEYOND;
                    end
                end
                else
                begin
                    d_status = ST_UNMAPPED;
                end
            end
        endcase
    end

    // Byte RAM ports: one byte per cycle in the run state, to or from the decoded store.
    logic       ext_en;
    logic       int_en;
    logic       rom_en;
    logic [7:0] wbyte;
    logic [7:0] ext_rdata;
    logic [7:0] int_rdata;
    logic [7:0] rom_rdata;
    logic [7:0] rbyte;

    assign ext_en = (state_reg == S_RUN) && (region_reg == RG_EXT);
    assign int_en = (state_reg == S_RUN) && (region_reg == RG_INT);
    assign rom_en = (state_reg == S_RUN) && (region_reg == RG_ROM);
    assign wbyte  = wdata_reg[8*idx_reg +: 8];

    mbrd_byte_ram #(.DEPTH(EXT_RAM_BYTES)) u_ext_ram (
        .clk   (clk),
        .en    (ext_en),
        .we    (wr_reg),
        .addr  (ptr_reg[EXT_AW-1:0]),
        .wdata (wbyte),
        .rdata (ext_rdata)
    );

    mbrd_byte_ram #(.DEPTH(INT_RAM_BYTES)) u_int_ram (
        .clk   (clk),
        .en    (int_en),
        .we    (wr_reg),
        .addr  (ptr_reg[INT_AW-1:0]),
        .wdata (wbyte),
        .rdata (int_rdata)
    );

    mbrd_byte_ram #(.DEPTH(ROM_BYTES)) u_rom_image (
        .clk   (clk),
        .en    (rom_en),
        .we    (wr_reg),
        .addr  (ptr_reg[ROM_AW-1:0]),
        .wdata (wbyte),
        .rdata (rom_rdata)
    );

    // The region does not change until the next request, so it selects the
    // read byte that returns in the cycle after its address was issued.
    always_comb
    begin
        case (region_reg)
            RG_EXT:  rbyte = ext_rdata;
            RG_INT:  rbyte = int_rdata;
            default: rbyte = rom_rdata;
        endcase
    end

    // Bytes that pass the end of the store continue at its start.
    logic [PTR_W-1:0] last_sel;
    logic [PTR_W-1:0] ptr_next;
    logic             last_byte;
    logic             out_free;

    always_comb
    begin
        case (region_reg)
            RG_EXT:  last_sel = EXT_LAST;
            RG_INT:  last_sel = INT_LAST;
            default: last_sel = ROM_LAST_OFF;
        endcase
    end

    assign ptr_next  = (ptr_reg == last_sel) ? '0 : ptr_reg + PTR_W'(1);
    assign last_byte = ({1'b0, idx_reg} + 3'd1) == cnt_reg;
    assign out_free  = !out_valid_reg || response.ready;

    assign request.ready              = (state_reg == S_IDLE);
    assign response.valid             = out_valid_reg;
    assign response.payload.read_data = out_rdata_reg;
    assign response.payload.status    = out_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // A read issued last cycle lands in its byte lane now.
            rd_pend_reg <= (state_reg == S_RUN) && !wr_reg;
            rd_lane_reg <= idx_reg;
            if (rd_pend_reg)
            begin
                rdata_reg[8*rd_lane_reg +: 8] <= rbyte;
            end

            // In the done state the response register is reloaded below instead.
            if (out_valid_reg && response.ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (request.valid)
                    begin
                        region_reg <= d_region;
                        wr_reg     <= d_wr;
                        ptr_reg    <= d_ptr;
                        cnt_reg    <= d_cnt;
                        idx_reg    <= 2'd0;
                        wdata_reg  <= request.payload.write_data;
                        rdata_reg  <= d_rdata;
                        status_reg <= d_status;
                        state_reg  <= (d_cnt == 3'd0) ? S_DONE : S_RUN;
                    end
                end
                S_RUN:
                begin
                    ptr_reg <= ptr_next;
                    idx_reg <= idx_reg + 2'd1;
                    if (last_byte)
                    begin
                        state_reg <= wr_reg ? S_DONE : S_TAIL;
                    end
                end
                S_TAIL:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_rdata_reg  <= wr_reg ? 32'd0 : rdata_reg;
                        out_status_reg <= status_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // At most one byte store is driven in any cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ext_en, int_en, rom_en}))
        else $error("more than one byte store enabled");

    // A write into the ROM image only comes from an image load.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rom_en && wr_reg) |-> (cnt_reg == 3'd1))
        else $error("ROM image written by a multi-byte access");

    // No read byte is still in flight when a new request is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready) |-> !rd_pend_reg)
        else $error("request accepted with a read byte outstanding");

    // A response is only loaded once the previous one has gone.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !response.ready) |=>
        (state_reg == S_DONE))
        else $error("response overwritten while stalled");

endmodule
